// File: hw/rtl/dadpcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dadpcm_pkg;

  localparam int PEAK_SLOTS_DEF   = 6;
  localparam int RES_FIFO_DEPTH   = 4;
  localparam int SPB_RESET        = 1024;
  localparam int MS_DELTA_RESET   = 16;
  localparam int MS_DELTA_FLOOR   = 16;
  localparam int STEP_INDEX_MAX   = 88;
  localparam int PRED_INDEX_LIMIT = 7;
  localparam int MIN_BLOCK_LEN    = 2;

  typedef enum logic [1:0] {
    OP_PEAK  = 2'd0,
    OP_START = 2'd1,
    OP_CODE  = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [7:0]         code_byte;
    logic signed [15:0] first_sample;
    logic signed [15:0] second_sample;
    logic signed [15:0] initial_delta;
    logic [7:0]         predictor_index;
    logic [7:0]         initial_step_index;
    logic [2:0]         slot;
    logic [15:0]        peak_position;
    logic signed [15:0] peak_revision;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [15:0]        sample_number;
    logic               last;
    logic               error;
  } res_t;

  // Up to two results produced by one request, before peak correction.
  typedef struct packed {
    logic [1:0] cnt;
    logic       peak_en;
    res_t       r0;
    res_t       r1;
  } res_pair_t;

  typedef struct packed {
    logic               en;
    logic [2:0]         slot;
    logic [15:0]        pos;
    logic signed [15:0] rev;
  } peak_wr_t;

  function automatic logic [9:0] adapt_lut(input logic [3:0] code);
    logic [9:0] v;
    unique case (code)
      4'd0, 4'd1, 4'd2, 4'd3: v = 10'd230;
      4'd4:                   v = 10'd307;
      4'd5:                   v = 10'd409;
      4'd6:                   v = 10'd512;
      4'd7:                   v = 10'd614;
      4'd8:                   v = 10'd768;
      4'd9:                   v = 10'd614;
      4'd10:                  v = 10'd512;
      4'd11:                  v = 10'd409;
      4'd12:                  v = 10'd307;
      default:                v = 10'd230;
    endcase
    return v;
  endfunction

  function automatic logic signed [11:0] coef_a_lut(input logic [2:0] sel);
    logic signed [11:0] v;
    unique case (sel)
      3'd1:    v = 12'sd512;
      3'd2:    v = 12'sd0;
      3'd3:    v = 12'sd192;
      3'd4:    v = 12'sd240;
      3'd5:    v = 12'sd460;
      3'd6:    v = 12'sd392;
      default: v = 12'sd256;
    endcase
    return v;
  endfunction

  function automatic logic signed [11:0] coef_b_lut(input logic [2:0] sel);
    logic signed [11:0] v;
    unique case (sel)
      3'd1:    v = -12'sd256;
      3'd3:    v = 12'sd64;
      3'd5:    v = -12'sd208;
      3'd6:    v = -12'sd232;
      default: v = 12'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [4:0] step_adj_lut(input logic [2:0] code);
    logic signed [4:0] v;
    unique case (code)
      3'd4:    v = 5'sd2;
      3'd5:    v = 5'sd4;
      3'd6:    v = 5'sd6;
      3'd7:    v = 5'sd8;
      default: v = -5'sd1;
    endcase
    return v;
  endfunction

  function automatic logic [14:0] step_lut(input logic [6:0] idx);
    logic [14:0] v;
    unique case (idx)
      7'd0:  v = 15'd7;     7'd1:  v = 15'd8;     7'd2:  v = 15'd9;
      7'd3:  v = 15'd10;    7'd4:  v = 15'd11;    7'd5:  v = 15'd12;
      7'd6:  v = 15'd13;    7'd7:  v = 15'd14;    7'd8:  v = 15'd16;
      7'd9:  v = 15'd17;    7'd10: v = 15'd19;    7'd11: v = 15'd21;
      7'd12: v = 15'd23;    7'd13: v = 15'd25;    7'd14: v = 15'd28;
      7'd15: v = 15'd31;    7'd16: v = 15'd34;    7'd17: v = 15'd37;
      7'd18: v = 15'd41;    7'd19: v = 15'd45;    7'd20: v = 15'd50;
      7'd21: v = 15'd55;    7'd22: v = 15'd60;    7'd23: v = 15'd66;
      7'd24: v = 15'd73;    7'd25: v = 15'd80;    7'd26: v = 15'd88;
      7'd27: v = 15'd97;    7'd28: v = 15'd107;   7'd29: v = 15'd118;
      7'd30: v = 15'd130;   7'd31: v = 15'd143;   7'd32: v = 15'd157;
      7'd33: v = 15'd173;   7'd34: v = 15'd190;   7'd35: v = 15'd209;
      7'd36: v = 15'd230;   7'd37: v = 15'd253;   7'd38: v = 15'd279;
      7'd39: v = 15'd307;   7'd40: v = 15'd337;   7'd41: v = 15'd371;
      7'd42: v = 15'd408;   7'd43: v = 15'd449;   7'd44: v = 15'd494;
      7'd45: v = 15'd544;   7'd46: v = 15'd598;   7'd47: v = 15'd658;
      7'd48: v = 15'd724;   7'd49: v = 15'd796;   7'd50: v = 15'd876;
      7'd51: v = 15'd963;   7'd52: v = 15'd1060;  7'd53: v = 15'd1166;
      7'd54: v = 15'd1282;  7'd55: v = 15'd1411;  7'd56: v = 15'd1552;
      7'd57: v = 15'd1707;  7'd58: v = 15'd1878;  7'd59: v = 15'd2066;
      7'd60: v = 15'd2272;  7'd61: v = 15'd2499;  7'd62: v = 15'd2749;
      7'd63: v = 15'd3024;  7'd64: v = 15'd3327;  7'd65: v = 15'd3660;
      7'd66: v = 15'd4026;  7'd67: v = 15'd4428;  7'd68: v = 15'd4871;
      7'd69: v = 15'd5358;  7'd70: v = 15'd5894;  7'd71: v = 15'd6484;
      7'd72: v = 15'd7132;  7'd73: v = 15'd7845;  7'd74: v = 15'd8630;
      7'd75: v = 15'd9493;  7'd76: v = 15'd10442; 7'd77: v = 15'd11487;
      7'd78: v = 15'd12635; 7'd79: v = 15'd13899; 7'd80: v = 15'd15289;
      7'd81: v = 15'd16818; 7'd82: v = 15'd18500; 7'd83: v = 15'd20350;
      7'd84: v = 15'd22385; 7'd85: v = 15'd24623; 7'd86: v = 15'd27086;
      7'd87: v = 15'd29794;
      default: v = 15'd32767;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    logic signed [15:0] r;
    if (v > 40'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -40'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dadpcm_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dadpcm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [7:0]         code_byte;
  logic signed [15:0] first_sample;
  logic signed [15:0] second_sample;
  logic signed [15:0] initial_delta;
  logic [7:0]         predictor_index;
  logic [7:0]         initial_step_index;
  logic [2:0]         slot;
  logic [15:0]        peak_position;
  logic signed [15:0] peak_revision;

  modport source (
    output valid, opcode, code_byte, first_sample, second_sample, initial_delta,
           predictor_index, initial_step_index, slot, peak_position, peak_revision,
    input  ready
  );
  modport sink (
    input  valid, opcode, code_byte, first_sample, second_sample, initial_delta,
           predictor_index, initial_step_index, slot, peak_position, peak_revision,
    output ready
  );
endinterface

interface dadpcm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic [15:0]        sample_number;
  logic               last;
  logic               error;

  modport source (output valid, sample, sample_number, last, error, input ready);
  modport sink (input valid, sample, sample_number, last, error, output ready);
endinterface

interface dadpcm_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dadpcm_core.sv
`timescale 1ns / 1ps
`default_nettype none

module dadpcm_core
  import dadpcm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_fire,
  input  wire in_item_t    in_item,
  input  wire logic        adv,
  input  wire logic [15:0] spb,
  output logic             a_valid,
  output res_pair_t        pair,
  output peak_wr_t         peak_wr
);

  logic               a_valid_r, a_valid_nxt;
  in_item_t           a_item_r;

  logic signed [15:0] hist1_r, hist1_nxt;
  logic signed [15:0] hist2_r, hist2_nxt;
  logic signed [31:0] delta_r, delta_nxt;
  logic [2:0]         coef_r, coef_nxt;
  logic signed [15:0] ima_prev_r, ima_prev_nxt;
  logic [6:0]         ima_idx_r, ima_idx_nxt;
  logic [15:0]        count_r, count_nxt;
  logic               failed_r, failed_nxt;

  // MS ADPCM datapath
  logic [3:0]         lo, hi;
  logic signed [42:0] nd_prod, nd_sh;
  logic signed [31:0] nd_clamped;
  logic signed [27:0] pred_sum, predict;
  logic signed [35:0] code_term;
  logic signed [36:0] ms_val;
  logic signed [15:0] ms_s;

  // IMA ADPCM datapath
  logic [14:0]        step;
  logic [16:0]        diff_mag;
  logic signed [17:0] diff_s, ima_sum;
  logic signed [15:0] ima_s;
  logic signed [7:0]  idx_sum;
  logic [6:0]         idx_clamped;

  logic signed [15:0] mix_s;
  logic [16:0]        num_inc, blen;
  logic               code_last, start_last;
  logic [6:0]         start_idx;

  assign lo = a_item_r.code_byte[3:0];
  assign hi = a_item_r.code_byte[7:4];

  assign nd_prod = 43'(signed'({1'b0, adapt_lut(lo)})) * 43'(delta_r);
  assign nd_sh   = nd_prod >>> 8;

  always_comb begin
    if (nd_sh < 43'(MS_DELTA_FLOOR)) begin
      nd_clamped = 32'(MS_DELTA_FLOOR);
    end else if (nd_sh > 43'sd2147483647) begin
      nd_clamped = 32'sh7fffffff;
    end else begin
      nd_clamped = nd_sh[31:0];
    end
  end

  assign pred_sum  = 28'(hist1_r) * 28'(coef_a_lut(coef_r)) +
                     28'(hist2_r) * 28'(coef_b_lut(coef_r));
  assign predict   = pred_sum >>> 8;
  assign code_term = 36'(signed'(lo)) * 36'(delta_r);
  assign ms_val    = 37'(code_term) + 37'(predict);
  assign ms_s      = sat16(40'(ms_val));

  assign step     = step_lut(ima_idx_r);
  assign diff_mag = 17'(step >> 3)
                  + (hi[0] ? 17'(step >> 2) : 17'd0)
                  + (hi[1] ? 17'(step >> 1) : 17'd0)
                  + (hi[2] ? 17'(step) : 17'd0);
  assign diff_s   = hi[3] ? -18'(signed'({1'b0, diff_mag})) : 18'(signed'({1'b0, diff_mag}));
  assign ima_sum  = 18'(ima_prev_r) + diff_s;
  assign ima_s    = sat16(40'(ima_sum));

  assign idx_sum = 8'(signed'({1'b0, ima_idx_r})) + 8'(step_adj_lut(hi[2:0]));
  always_comb begin
    if (idx_sum < 8'sd0) begin
      idx_clamped = 7'd0;
    end else if (idx_sum > 8'(STEP_INDEX_MAX)) begin
      idx_clamped = 7'(STEP_INDEX_MAX);
    end else begin
      idx_clamped = idx_sum[6:0];
    end
  end

  assign mix_s = sat16(40'(17'(ms_s) + 17'(ima_s)));

  // A block is never shorter than its two header samples.
  assign blen       = (spb < 16'(MIN_BLOCK_LEN)) ? 17'(MIN_BLOCK_LEN) : 17'(spb);
  assign num_inc    = 17'(count_r) + 17'd1;
  assign code_last  = num_inc >= blen;
  assign start_last = blen <= 17'(MIN_BLOCK_LEN);
  assign start_idx  = (a_item_r.initial_step_index > 8'(STEP_INDEX_MAX)) ?
                      7'(STEP_INDEX_MAX) : a_item_r.initial_step_index[6:0];

  always_comb begin
    hist1_nxt    = hist1_r;
    hist2_nxt    = hist2_r;
    delta_nxt    = delta_r;
    coef_nxt     = coef_r;
    ima_prev_nxt = ima_prev_r;
    ima_idx_nxt  = ima_idx_r;
    count_nxt    = count_r;
    failed_nxt   = failed_r;
    pair         = '0;
    peak_wr.en   = 1'b0;
    peak_wr.slot = a_item_r.slot;
    peak_wr.pos  = a_item_r.peak_position;
    peak_wr.rev  = a_item_r.peak_revision;
    if (a_valid_r) begin
      unique case (a_item_r.opcode)
        OP_PEAK: begin
          peak_wr.en = 1'b1;
        end
        OP_START: begin
          if (a_item_r.predictor_index >= 8'(PRED_INDEX_LIMIT)) begin
            failed_nxt       = 1'b1;
            pair.cnt         = 2'd1;
            pair.r0.last     = 1'b1;
            pair.r0.error    = 1'b1;
          end else begin
            hist2_nxt    = a_item_r.first_sample;
            hist1_nxt    = a_item_r.second_sample;
            delta_nxt    = 32'(a_item_r.initial_delta);
            coef_nxt     = a_item_r.predictor_index[2:0];
            ima_prev_nxt = '0;
            ima_idx_nxt  = start_idx;
            count_nxt    = 16'd2;
            failed_nxt   = start_last;
            pair.cnt     = 2'd2;
            pair.peak_en = 1'b1;
            pair.r0.sample        = a_item_r.first_sample;
            pair.r0.sample_number = 16'd0;
            pair.r1.sample        = a_item_r.second_sample;
            pair.r1.sample_number = 16'd1;
            pair.r1.last          = start_last;
          end
        end
        OP_CODE: begin
          if (!failed_r) begin
            delta_nxt    = nd_clamped;
            hist2_nxt    = hist1_r;
            hist1_nxt    = ms_s;
            ima_prev_nxt = ima_s;
            ima_idx_nxt  = idx_clamped;
            count_nxt    = num_inc[15:0];
            if (code_last) begin
              failed_nxt = 1'b1;
            end
            pair.cnt              = 2'd1;
            pair.peak_en          = 1'b1;
            pair.r0.sample        = mix_s;
            pair.r0.sample_number = count_r;
            pair.r0.last          = code_last;
          end
        end
        default: begin
        end
      endcase
    end
    if (!adv) begin
      pair.cnt   = 2'd0;
      peak_wr.en = 1'b0;
    end
  end

  always_comb begin
    if (in_fire) begin
      a_valid_nxt = 1'b1;
    end else if (adv) begin
      a_valid_nxt = 1'b0;
    end else begin
      a_valid_nxt = a_valid_r;
    end
  end

  assign a_valid = a_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r  <= 1'b0;
      hist1_r    <= '0;
      hist2_r    <= '0;
      delta_r    <= 32'(MS_DELTA_RESET);
      coef_r     <= '0;
      ima_prev_r <= '0;
      ima_idx_r  <= '0;
      count_r    <= '0;
      failed_r   <= 1'b1;
    end else begin
      a_valid_r <= a_valid_nxt;
      if (adv) begin
        hist1_r    <= hist1_nxt;
        hist2_r    <= hist2_nxt;
        delta_r    <= delta_nxt;
        coef_r     <= coef_nxt;
        ima_prev_r <= ima_prev_nxt;
        ima_idx_r  <= ima_idx_nxt;
        count_r    <= count_nxt;
        failed_r   <= failed_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dadpcm_peak.sv
`timescale 1ns / 1ps
`default_nettype none

module dadpcm_peak
  import dadpcm_pkg::*;
#(
  parameter int PEAK_SLOTS = PEAK_SLOTS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      adv,
  input  wire res_pair_t pair_in,
  input  wire peak_wr_t  peak_wr,
  output res_pair_t      push
);

  logic [15:0]        pos_r [PEAK_SLOTS];
  logic signed [15:0] rev_r [PEAK_SLOTS];
  res_pair_t          b_r;
  logic [1:0]         b_cnt_r;
  logic signed [15:0] s0, s1;

  // A peak load written at the edge where the older item leaves this stage
  // is seen only by later items.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PEAK_SLOTS; i++) begin
        pos_r[i] <= '0;
        rev_r[i] <= '0;
      end
    end else if (peak_wr.en) begin
      for (int i = 0; i < PEAK_SLOTS; i++) begin
        if (int'(peak_wr.slot) == i) begin
          pos_r[i] <= peak_wr.pos;
          rev_r[i] <= peak_wr.rev;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_cnt_r <= '0;
    end else if (adv) begin
      b_cnt_r <= pair_in.cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_r <= pair_in;
    end
  end

  // Matching revisions are subtracted in slot order, saturating each time.
  always_comb begin
    s0 = b_r.r0.sample;
    s1 = b_r.r1.sample;
    if (b_r.peak_en) begin
      for (int i = 0; i < PEAK_SLOTS; i++) begin
        if (rev_r[i] != 16'sd0 && pos_r[i] == b_r.r0.sample_number) begin
          s0 = sat16(40'(s0) - 40'(rev_r[i]));
        end
        if (rev_r[i] != 16'sd0 && pos_r[i] == b_r.r1.sample_number) begin
          s1 = sat16(40'(s1) - 40'(rev_r[i]));
        end
      end
    end
  end

  always_comb begin
    push           = b_r;
    push.cnt       = adv ? b_cnt_r : 2'd0;
    push.r0.sample = s0;
    push.r1.sample = s1;
  end

endmodule

`default_nettype wire

// File: hw/rtl/dadpcm_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module dadpcm_fifo
  import dadpcm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire res_pair_t push,
  input  wire logic      pop,
  output logic           room,
  output logic           out_valid,
  output res_t           out_res
);

  localparam int PtrW = $clog2(RES_FIFO_DEPTH);
  localparam int CntW = $clog2(RES_FIFO_DEPTH + 1);

  res_t            mem [RES_FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_pop;

  assign do_pop    = pop && (count_r != '0);
  assign out_valid = count_r != '0;
  assign out_res   = mem[rd_ptr_r];
  // Two free entries cover the largest request's results.
  assign room      = count_r <= CntW'(RES_FIFO_DEPTH - 2);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PtrW'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + (do_pop ? PtrW'(1) : PtrW'(0));
    count_nxt  = count_r + CntW'(push.cnt) - (do_pop ? CntW'(1) : CntW'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_r + PtrW'(1)] <= push.r1;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dual_adpcm_block_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake          Payload
// in_port   in   valid / ready      opcode, code byte, block header, peak load
// out_port  out  valid / ready      sample, sample_number, last, error
// cfg_port  in   valid / ready      samples_per_block (16 bits)
//
// One request is accepted per cycle while the result buffer has room;
// a valid block start yields two results, a rejected one an error
// result, the others one or none. Results pass the input register, the
// decode register and the result buffer. A four-entry result buffer
// lets the decoder run on while out_port stalls; in_port drops ready
// while the input register holds a request and fewer than two entries
// are free. Reset (rst_n low, synchronous) leaves no block active.

module dual_adpcm_block_decoder_core
  import dadpcm_pkg::*;
#(
  parameter int PEAK_SLOTS = PEAK_SLOTS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  dadpcm_in_if.sink    in_port,
  dadpcm_out_if.source out_port,
  dadpcm_cfg_if.sink   cfg_port
);

  logic [15:0] spb_r;
  logic        adv;
  logic        a_valid;
  logic        in_fire;
  in_item_t    in_item;
  res_pair_t   pair;
  res_pair_t   push;
  peak_wr_t    peak_wr;
  res_t        out_res;

  assign cfg_port.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spb_r <= 16'(SPB_RESET);
    end else if (cfg_port.valid) begin
      spb_r <= cfg_port.data;
    end
  end

  assign in_port.ready = !a_valid || adv;
  assign in_fire       = in_port.valid && in_port.ready;

  always_comb begin
    in_item.opcode             = in_port.opcode;
    in_item.code_byte          = in_port.code_byte;
    in_item.first_sample       = in_port.first_sample;
    in_item.second_sample      = in_port.second_sample;
    in_item.initial_delta      = in_port.initial_delta;
    in_item.predictor_index    = in_port.predictor_index;
    in_item.initial_step_index = in_port.initial_step_index;
    in_item.slot               = in_port.slot;
    in_item.peak_position      = in_port.peak_position;
    in_item.peak_revision      = in_port.peak_revision;
  end

  dadpcm_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_item (in_item),
    .adv     (adv),
    .spb     (spb_r),
    .a_valid (a_valid),
    .pair    (pair),
    .peak_wr (peak_wr)
  );

  dadpcm_peak #(
    .PEAK_SLOTS (PEAK_SLOTS)
  ) u_peak (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .pair_in (pair),
    .peak_wr (peak_wr),
    .push    (push)
  );

  dadpcm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_port.ready),
    .room      (adv),
    .out_valid (out_port.valid),
    .out_res   (out_res)
  );

  assign out_port.sample        = out_res.sample;
  assign out_port.sample_number = out_res.sample_number;
  assign out_port.last          = out_res.last;
  assign out_port.error         = out_res.error;

endmodule

`default_nettype wire
